FILE: hdl/bspc_pkg.sv
// ----------------------------------------------------------------------------
// bspc_pkg
// shared codes, widths and control types for the bounded stack with peek
// ----------------------------------------------------------------------------
`default_nettype none

package bspc_pkg;

  localparam int DEPTH_DEF = 8;

  localparam int FUNC_W   = 2;
  localparam int WORD_W   = 32;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 2;
  localparam int DEPTH_W  = 4;
  localparam int CAP_W    = 4;

  localparam logic [CAP_W-1:0] CAP_RESET = 4'd5;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_PUSH   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_POP    = 2'd1;
  localparam logic [FUNC_W-1:0] FN_PEEK   = 2'd2;
  localparam logic [FUNC_W-1:0] FN_CHANGE = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADPOS    = 2'd3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;  // take the item at the input ports
    logic load;    // move the finished result into the output register
  } bspc_cmd_t;

endpackage

`default_nettype wire

FILE: hdl/bspc_ctrl.sv
// ----------------------------------------------------------------------------
// bspc_ctrl
// two-state controller: take an item, then hand its result to the output
// ----------------------------------------------------------------------------
`default_nettype none

module bspc_ctrl
  import bspc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  output bspc_cmd_t      cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;
  logic out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd.accept = 1'b0;
    cmd.load   = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        // memory read data is ready here
        if (out_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/bspc_dp.sv
// ----------------------------------------------------------------------------
// bspc_dp
// stack datapath: entry memory, entry count, capacity register, result regs
// ----------------------------------------------------------------------------
`default_nettype none

module bspc_dp
  import bspc_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire bspc_cmd_t                  cmd,
  input  wire logic                       cfg_we,
  input  wire logic        [CAP_W-1:0]    cfg_wdata,
  input  wire logic        [FUNC_W-1:0]   func,
  input  wire logic signed [WORD_W-1:0]   value,
  input  wire logic        [POS_W-1:0]    position,
  output logic signed      [WORD_W-1:0]   data,
  output logic             [STATUS_W-1:0] status,
  output logic             [DEPTH_W-1:0]  depth
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);
  localparam logic [CMP_W-1:0] ONE_C   = CMP_W'(1);

  logic signed [WORD_W-1:0] mem [DEPTH];
  logic signed [WORD_W-1:0] rd_q;

  logic [CAP_W-1:0]    capacity;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic [STATUS_W-1:0] st_q;
  logic [STATUS_W-1:0] st_next;
  logic                use_rd;
  logic                use_rd_next;

  logic [CMP_W-1:0]  cnt_x;
  logic [CMP_W-1:0]  cap_x;
  logic [CMP_W-1:0]  pos_x;
  logic [CMP_W-1:0]  slot_x;
  logic [ADDR_W-1:0] addr;
  logic              wr_en;
  logic              rd_en;

  assign cnt_x  = CMP_W'(count);
  assign cap_x  = CMP_W'(capacity);
  assign pos_x  = CMP_W'(position);
  assign slot_x = cnt_x - pos_x;

  // decode of one item against the current count
  always_comb begin
    count_next  = count;
    st_next     = ST_OK;
    use_rd_next = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    addr        = ADDR_W'(cnt_x);
    case (func)
      FN_PUSH: begin
        if (cnt_x < cap_x && cnt_x < DEPTH_C) begin
          wr_en      = 1'b1;
          count_next = count + CNT_W'(1);
        end else begin
          st_next = ST_OVERFLOW;
        end
      end
      FN_POP: begin
        addr = ADDR_W'(cnt_x - ONE_C);
        if (count == '0) begin
          st_next = ST_UNDERFLOW;
        end else begin
          rd_en       = 1'b1;
          use_rd_next = 1'b1;
          count_next  = count - CNT_W'(1);
        end
      end
      FN_PEEK, FN_CHANGE: begin
        addr = ADDR_W'(slot_x);
        if (position == '0 || pos_x > cnt_x) begin
          st_next = ST_BADPOS;
        end else if (func == FN_PEEK) begin
          rd_en       = 1'b1;
          use_rd_next = 1'b1;
        end else begin
          wr_en = 1'b1;
        end
      end
      default: st_next = ST_OK;
    endcase
  end

  // entry memory, one access per item
  always_ff @(posedge clk) begin
    if (cmd.accept && wr_en) begin
      mem[addr] <= value;
    end
    if (cmd.accept && rd_en) begin
      rd_q <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      count    <= '0;
      st_q     <= ST_OK;
      use_rd   <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (cmd.accept) begin
        count  <= count_next;
        st_q   <= st_next;
        use_rd <= use_rd_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      data   <= use_rd ? rd_q : '0;
      status <= st_q;
      depth  <= cnt_x[DEPTH_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/bounded_stack_peek_change_top.sv
// ----------------------------------------------------------------------------
// bounded_stack_peek_change_top
// bounded lifo of signed words with push, pop, peek and change by position
// ----------------------------------------------------------------------------
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------
//   in       | in_valid / in_stall  | func, value, position
//   out      | out_valid / out_stall| data, status, depth
//   cfg      | cfg_we               | cfg_wdata (capacity)
//
// an item is taken in the idle state, which decodes it and does the one
// memory access; the read state then moves the registered read into the
// output register, as the single-port entry memory has a registered read
// a held result waits in the output register while the next item is taken
// a stalled output holds the read state, so in_stall stays high
// reset (rst, synchronous) empties the stack and sets capacity to five;
// entry contents are not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_stack_peek_change_top
  import bspc_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // configuration
  input  wire logic                       cfg_we,
  input  wire logic        [CAP_W-1:0]    cfg_wdata,
  // item in
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic        [FUNC_W-1:0]   func,
  input  wire logic signed [WORD_W-1:0]   value,
  input  wire logic        [POS_W-1:0]    position,
  // result out
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed      [WORD_W-1:0]   data,
  output logic             [STATUS_W-1:0] status,
  output logic             [DEPTH_W-1:0]  depth
);

  bspc_cmd_t cmd;

  // sequencing of accept and result load
  bspc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // memory, count, capacity and result registers
  bspc_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .func      (func),
    .value     (value),
    .position  (position),
    .data      (data),
    .status    (status),
    .depth     (depth)
  );

endmodule

`default_nettype wire
